// ===== rtl/fuzzy_kp_gain_schedule_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fuzzy Kp gain schedule unit
// Shared property wrappers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FUZZY_KP_GAIN_SCHEDULE_UNIT_DEFINES_SVH
`define FUZZY_KP_GAIN_SCHEDULE_UNIT_DEFINES_SVH

// expression must never hold
`define FKGS_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FKGS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fkgs_pkg.sv =====
// ----------------------------------------------------------------------------
// fkgs_pkg
// Types, rule table and fixed constants of the fuzzy Kp gain schedule unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fkgs_pkg;

	localparam int WGT_W = 17;
	localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;
	localparam int OFF_W = 20;
	localparam int LVL_W = 8;
	localparam int LEVEL_W = 11;
	localparam int NUM_W = 28;
	localparam int DEN_W = 19;
	localparam int GAIN_W = 18;
	localparam int GAIN_INT_W = 10;
	localparam int KPM_W = 10;

	// floor(x/5) = (x * RECIP5) >> RECIP5_SH, exact for x below 2^22
	localparam logic [OFF_W-1:0] RECIP5 = 20'd838861;
	localparam int RECIP5_SH = 22;
	// floor(x/6) = (x * KP_RECIP6) >> KP_RECIP6_SH, exact for 10-bit x
	localparam logic [KPM_W+9:0] KP_RECIP6 = 20'd683;
	localparam int KP_RECIP6_SH = 12;
	localparam logic [LVL_W-1:0] KP_STEP_RST = 8'd33;

	typedef logic [2:0] lab_t;

	localparam lab_t LABEL_TAB [7][7] = '{
		'{3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd0, 3'd0},
		'{3'd6, 3'd4, 3'd3, 3'd3, 3'd2, 3'd0, 3'd0},
		'{3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2},
		'{3'd2, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd2},
		'{3'd2, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
		'{3'd0, 3'd0, 3'd2, 3'd3, 3'd3, 3'd4, 3'd6},
		'{3'd0, 3'd1, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6}
	};
	localparam int ERR_PTS [7] = '{-30, -20, -10, 0, 10, 20, 30};
	localparam int CHG_PTS [7] = '{-15, -10, -5, 0, 5, 10, 15};

	typedef struct packed {
		logic             below;
		logic             above;
		logic [2:0]       row;
		logic [OFF_W-1:0] off;
	} fz_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/fkgs_front.sv =====
// ----------------------------------------------------------------------------
// fkgs_front
// Fuzzifies both inputs, fires and prunes the four rules and forms the
// numerator and denominator of the weighted average.
// ----------------------------------------------------------------------------
`default_nettype none
module fkgs_front #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic signed [15:0]           error,
	input  wire logic signed [15:0]           error_change,
	input  wire logic [fkgs_pkg::LVL_W-1:0]   kp_step,
	output logic                              push,
	output logic [fkgs_pkg::NUM_W-1:0]        num,
	output logic [fkgs_pkg::DEN_W-1:0]        den
);
	import fkgs_pkg::*;

	function automatic fz_t fuzz(input logic signed [15:0] x, input logic sel_err);
		logic signed [23:0] xs;
		logic signed [23:0] bp [7];
		logic [2:0] cnt;
		logic [2:0] idx;
		fz_t r;
		xs = 24'(x);
		cnt = '0;
		for (int j = 0; j < 7; j++) begin
			bp[j] = sel_err ? 24'(ERR_PTS[j] * (2 ** FRAC_BITS))
			                : 24'(CHG_PTS[j] * (2 ** FRAC_BITS));
		end
		for (int j = 0; j < 7; j++) begin
			if (bp[j] < xs)
				cnt = cnt + 3'd1;
		end
		idx = (cnt == 3'd7) ? 3'd6 : cnt;
		r.below = (xs <= bp[0]);
		r.above = (xs >= bp[6]);
		if (cnt == 3'd0 || cnt == 3'd7)
			r.row = (cnt == 3'd0) ? 3'd0 : 3'd5;
		else
			r.row = cnt - 3'd1;
		r.off = OFF_W'(bp[idx] - xs);
		return r;
	endfunction

	// stage 1: segment search
	logic vld_s1;
	fz_t  fe_s1, fc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= take;
	end

	always_ff @(posedge clk) begin
		fe_s1 <= fuzz(error, 1'b1);
		fc_s1 <= fuzz(error_change, 1'b0);
	end

	// stage 2: weights, divide offset by the step through a reciprocal
	logic [OFF_W-1:0]   sc_e, sc_c;
	logic [2*OFF_W-1:0] pr_e, pr_c;
	logic               vld_s2;
	logic [2:0]         er_s2, cr_s2;
	logic [WGT_W-1:0]   ew_s2, cw_s2;

	always_comb begin
		sc_e = OFF_W'(fe_s1.off << (16 - FRAC_BITS));
		sc_c = OFF_W'(fc_s1.off << (16 - FRAC_BITS));
		pr_e = (2*OFF_W)'(sc_e >> 1) * (2*OFF_W)'(RECIP5);
		pr_c = (2*OFF_W)'(sc_c) * (2*OFF_W)'(RECIP5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		er_s2 <= fe_s1.row;
		cr_s2 <= fc_s1.row;
		if (fe_s1.below)
			ew_s2 <= WGT_ONE;
		else if (fe_s1.above)
			ew_s2 <= '0;
		else
			ew_s2 <= pr_e[RECIP5_SH+WGT_W-1:RECIP5_SH];
		if (fc_s1.below)
			cw_s2 <= WGT_ONE;
		else if (fc_s1.above)
			cw_s2 <= '0;
		else
			cw_s2 <= pr_c[RECIP5_SH+WGT_W-1:RECIP5_SH];
	end

	// stage 3: rule firing and duplicate pruning
	lab_t             lab [4];
	logic [WGT_W-1:0] wt [4];
	logic [WGT_W-1:0] ew1, cw1;
	logic             vld_s3;
	logic [WGT_W-1:0] wt_s3 [4];
	logic [LEVEL_W-1:0] level_s3 [4];

	always_comb begin
		ew1 = WGT_ONE - ew_s2;
		cw1 = WGT_ONE - cw_s2;
		lab[0] = LABEL_TAB[er_s2][cr_s2];
		lab[1] = LABEL_TAB[er_s2 + 3'd1][cr_s2];
		lab[2] = LABEL_TAB[er_s2][cr_s2 + 3'd1];
		lab[3] = LABEL_TAB[er_s2 + 3'd1][cr_s2 + 3'd1];
		wt[0] = (ew_s2 <= cw_s2) ? ew_s2 : cw_s2;
		wt[1] = (ew1 <= cw_s2) ? ew1 : cw_s2;
		wt[2] = (ew_s2 <= cw1) ? ew_s2 : cw1;
		wt[3] = (ew1 <= cw1) ? ew1 : cw1;
		// pairs in order; a tie drops the first rule
		for (int a = 0; a < 3; a++) begin
			for (int b = a + 1; b < 4; b++) begin
				if (lab[a] == lab[b]) begin
					if (wt[a] > wt[b])
						wt[b] = '0;
					else
						wt[a] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			wt_s3[k]    <= wt[k];
			level_s3[k] <= LEVEL_W'(kp_step) * LEVEL_W'(lab[k]);
		end
	end

	// stage 4: weighted levels
	logic             vld_s4;
	logic [NUM_W-1:0] prod_s4 [4];
	logic [WGT_W-1:0] wt_s4 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s4[k] <= NUM_W'(wt_s3[k]) * NUM_W'(level_s3[k]);
			wt_s4[k]   <= wt_s3[k];
		end
	end

	// stage 5: sums
	logic             vld_s5;
	logic [NUM_W-1:0] num_s5;
	logic [DEN_W-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		num_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2] + prod_s4[3];
		den_s5 <= DEN_W'(wt_s4[0]) + DEN_W'(wt_s4[1]) + DEN_W'(wt_s4[2])
		        + DEN_W'(wt_s4[3]);
	end

	assign push = vld_s5;
	assign num  = num_s5;
	assign den  = den_s5;

endmodule
`default_nettype wire

// ===== rtl/fkgs_queue.sv =====
// ----------------------------------------------------------------------------
// fkgs_queue
// Two-entry queue of numerator and denominator pairs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module fkgs_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [fkgs_pkg::NUM_W-1:0]    num_in,
	input  wire logic [fkgs_pkg::DEN_W-1:0]    den_in,
	input  wire logic                          pop,
	output logic [fkgs_pkg::NUM_W-1:0]         num_out,
	output logic [fkgs_pkg::DEN_W-1:0]         den_out,
	output fkgs_pkg::q_stat_t                  stat
);
	import fkgs_pkg::*;

	logic [NUM_W-1:0] num_q [2];
	logic [DEN_W-1:0] den_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			num_q[wr_q] <= num_in;
			den_q[wr_q] <= den_in;
		end
	end

	assign num_out = num_q[rd_q];
	assign den_out = den_q[rd_q];

endmodule
`default_nettype wire

// ===== rtl/fkgs_div.sv =====
// ----------------------------------------------------------------------------
// fkgs_div
// Pipelined restoring divider: one quotient bit per stage, gives the gain.
// ----------------------------------------------------------------------------
`default_nettype none
module fkgs_div #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vld_in,
	input  wire logic [fkgs_pkg::NUM_W-1:0]    num,
	input  wire logic [fkgs_pkg::DEN_W-1:0]    den,
	output logic                               done,
	output logic [fkgs_pkg::GAIN_W-1:0]        gain
);
	import fkgs_pkg::*;

	// the average never reaches 2^GAIN_INT_W, so QW quotient bits suffice
	localparam int QW = GAIN_INT_W + FRAC_BITS;

	logic             vld_s [QW+1];
	logic [DEN_W:0]   rem_s [QW+1];
	logic [QW-1:0]    low_s [QW+1];
	logic [QW-1:0]    quo_s [QW+1];
	logic [DEN_W-1:0] den_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else
			vld_s[0] <= vld_in;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= (DEN_W+1)'(num[NUM_W-1:GAIN_INT_W]);
		low_s[0] <= {num[GAIN_INT_W-1:0], {FRAC_BITS{1'b0}}};
		quo_s[0] <= '0;
		den_s[0] <= den;
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;

		always_comb begin
			trial = {rem_s[i][DEN_W-1:0], low_s[i][QW-1]};
			ge    = (trial >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (trial - {1'b0, den_s[i]}) : trial;
			low_s[i+1] <= low_s[i] << 1;
			quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
			den_s[i+1] <= den_s[i];
		end
	end

	logic              done_q;
	logic [GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s[QW];
	end

	// zero weight sum gives zero gain
	always_ff @(posedge clk) begin
		gain_q <= (den_s[QW] == '0) ? '0 : GAIN_W'(quo_s[QW]);
	end

	assign done = done_q;
	assign gain = gain_q;

endmodule
`default_nettype wire

// ===== rtl/fuzzy_kp_gain_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// fuzzy_kp_gain_schedule_unit
// Fuzzy scheduler of a proportional gain from error and error change.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge with start high and busy low, one
// per cycle with no gaps. Its gain appears on gain with done high for exactly
// one cycle, in input order; the receiver cannot stall, so gain must be
// captured when done is high. The path runs through the five-stage front end,
// the queue, and the restoring divider with one stage per quotient bit
// (10 + FRAC_BITS stages). The user must write kp_max with kp_max_we only while
// no transaction is in flight; the block does not enforce it. The held step
// resets to 33, floor(200/6), as if kp_max were 200.
`default_nettype none
module fuzzy_kp_gain_schedule_unit #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic signed [15:0]                 error,
	input  wire logic signed [15:0]                 error_change,
	output logic                                    done,
	output logic [fkgs_pkg::GAIN_W-1:0]             gain,
	input  wire logic                               kp_max_we,
	input  wire logic [fkgs_pkg::KPM_W-1:0]         kp_max
);
	import fkgs_pkg::*;

	logic [LVL_W-1:0] kp_step_q;
	logic [KPM_W+9:0] kp_prod;

	assign kp_prod = (KPM_W+10)'(kp_max) * KP_RECIP6;

	// hold floor(kp_max/6) rather than kp_max itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kp_step_q <= KP_STEP_RST;
		else if (kp_max_we)
			kp_step_q <= LVL_W'(kp_prod >> KP_RECIP6_SH);
	end

	logic             take;
	logic             push;
	logic [NUM_W-1:0] f_num, q_num;
	logic [DEN_W-1:0] f_den, q_den;
	q_stat_t          qstat;
	logic             pop;

	assign busy = qstat.full;
	assign take = start && !busy;
	assign pop  = !qstat.empty;

	fkgs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.error        (error),
		.error_change (error_change),
		.kp_step      (kp_step_q),
		.push         (push),
		.num          (f_num),
		.den          (f_den)
	);

	fkgs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.num_in  (f_num),
		.den_in  (f_den),
		.pop     (pop),
		.num_out (q_num),
		.den_out (q_den),
		.stat    (qstat)
	);

	fkgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (pop),
		.num    (q_num),
		.den    (q_den),
		.done   (done),
		.gain   (gain)
	);

`include "fuzzy_kp_gain_schedule_unit_defines.svh"

	`FKGS_ASSERT_NEVER(a_queue_overflow, push && qstat.full, "queue overflow")
	`FKGS_ASSERT_NEVER(a_queue_state, qstat.full && qstat.empty, "queue full and empty")
	`FKGS_ASSERT_IMPLY(a_drain, !qstat.empty, pop, "queue not drained")

endmodule
`default_nettype wire
